// ===== rtl/ffalloc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffalloc_pkg: shared types and codes of the first-fit job allocator
// Item layouts, controller commands and status, and default sizes.
// ----------------------------------------------------------------------------
package ffalloc_pkg;

   // Default sizes of the tables and of the address space.
   localparam int RUN_SLOTS_DEF  = 32;
   localparam int WAIT_DEPTH_DEF = 32;
   localparam int ADDR_BITS_DEF  = 16;

   // Pool size after reset.
   localparam logic [15:0] RESET_MEM_SIZE = 16'hFFFF;

   // One input item: an optional arriving job.
   typedef struct packed {
      logic        job_arrives;
      logic [15:0] job_mem_len;
      logic [15:0] job_run_len;
   } req_type;

   // One result item, produced once per tick.
   typedef struct packed {
      logic [31:0] now_time;
      logic        placed;
      logic [15:0] placed_addr;
      logic [31:0] waited_total;
      logic [5:0]  running_count;
      logic [5:0]  waiting_count;
      logic        dropped;
   } rsp_type;

   // Datapath operation codes issued by the controller.
   typedef logic [3:0] op_code_type;

   localparam op_code_type OP_NONE       = 4'd0;
   localparam op_code_type OP_LOAD       = 4'd1;
   localparam op_code_type OP_RUN_RD     = 4'd2;
   localparam op_code_type OP_RUN_CHK    = 4'd3;
   localparam op_code_type OP_SCAN_REL   = 4'd4;
   localparam op_code_type OP_REL_APPLY  = 4'd5;
   localparam op_code_type OP_WAIT_RD    = 4'd6;
   localparam op_code_type OP_SCAN_WAIT  = 4'd7;
   localparam op_code_type OP_WAIT_APPLY = 4'd8;
   localparam op_code_type OP_ARR_CHECK  = 4'd9;
   localparam op_code_type OP_SCAN_ARR   = 4'd10;
   localparam op_code_type OP_ARR_APPLY  = 4'd11;
   localparam op_code_type OP_DONE       = 4'd12;

   // Command from controller to datapath.
   typedef struct packed {
      op_code_type op;
      logic        scan_first;  // first cycle of a free-table scan
      logic        scan_issue;  // a free-table read is issued this cycle
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic expired;     // the running entry just read finishes now
      logic wait_nz;     // the wait queue holds at least one job
      logic seg_found;   // the last fit scan found a segment
      logic slot_found;  // the last fit scan found a free running slot
      logic arr_go;      // the arrival needs a fit scan
   } stat_type;

endpackage

// ===== rtl/ffalloc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffalloc_ctrl: tick sequencer of the first-fit job allocator
// Walks the running table, the wait queue and the arrival through the
// datapath, one table entry per step, and steps the index through each free-table scan.
// ----------------------------------------------------------------------------
module ffalloc_ctrl #(
   parameter int RUN_SLOTS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  ffalloc_pkg::stat_type                stat,
   output ffalloc_pkg::cmd_type                 cmd,
   output logic [$clog2(RUN_SLOTS + 2) - 1:0]   idx
);
   import ffalloc_pkg::*;

   localparam int SEG_SLOTS = RUN_SLOTS + 1;
   localparam int IW        = $clog2(RUN_SLOTS + 2);

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_RUN_RD     = 4'd1;
   localparam logic [3:0] ST_RUN_CHK    = 4'd2;
   localparam logic [3:0] ST_REL_SCAN   = 4'd3;
   localparam logic [3:0] ST_REL_APPLY  = 4'd4;
   localparam logic [3:0] ST_WAIT_TRY   = 4'd5;
   localparam logic [3:0] ST_WAIT_SCAN  = 4'd6;
   localparam logic [3:0] ST_WAIT_APPLY = 4'd7;
   localparam logic [3:0] ST_ARRIVE     = 4'd8;
   localparam logic [3:0] ST_ARR_SCAN   = 4'd9;
   localparam logic [3:0] ST_ARR_APPLY  = 4'd10;
   localparam logic [3:0] ST_DONE       = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic [IW-1:0] sidx_ff, sidx_in;
   logic          run_last;
   logic          scan_last;

   assign run_last  = (ridx_ff == IW'(RUN_SLOTS - 1));
   assign scan_last = (sidx_ff == IW'(SEG_SLOTS));
   assign busy      = (state_ff != ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in       = state_ff;
      ridx_in        = ridx_ff;
      sidx_in        = sidx_ff;
      cmd.op         = OP_NONE;
      cmd.scan_first = (sidx_ff == '0);
      cmd.scan_issue = (sidx_ff < IW'(SEG_SLOTS));
      idx            = sidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               ridx_in  = '0;
               state_in = ST_RUN_RD;
            end
         end
         ST_RUN_RD: begin
            cmd.op   = OP_RUN_RD;
            idx      = ridx_ff;
            state_in = ST_RUN_CHK;
         end
         ST_RUN_CHK: begin
            cmd.op = OP_RUN_CHK;
            if (stat.expired) begin
               sidx_in  = '0;
               state_in = ST_REL_SCAN;
            end else if (run_last) begin
               state_in = ST_WAIT_TRY;
            end else begin
               ridx_in  = ridx_ff + IW'(1);
               state_in = ST_RUN_RD;
            end
         end
         ST_REL_SCAN: begin
            cmd.op  = OP_SCAN_REL;
            sidx_in = sidx_ff + IW'(1);
            if (scan_last) begin
               state_in = ST_REL_APPLY;
            end
         end
         ST_REL_APPLY: begin
            cmd.op = OP_REL_APPLY;
            if (run_last) begin
               state_in = ST_WAIT_TRY;
            end else begin
               ridx_in  = ridx_ff + IW'(1);
               state_in = ST_RUN_RD;
            end
         end
         ST_WAIT_TRY: begin
            if (stat.wait_nz) begin
               cmd.op   = OP_WAIT_RD;
               sidx_in  = '0;
               state_in = ST_WAIT_SCAN;
            end else begin
               state_in = ST_ARRIVE;
            end
         end
         ST_WAIT_SCAN: begin
            cmd.op  = OP_SCAN_WAIT;
            sidx_in = sidx_ff + IW'(1);
            if (scan_last) begin
               state_in = ST_WAIT_APPLY;
            end
         end
         ST_WAIT_APPLY: begin
            cmd.op = OP_WAIT_APPLY;
            if (stat.seg_found && stat.slot_found) begin
               state_in = ST_WAIT_TRY;
            end else begin
               state_in = ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            cmd.op = OP_ARR_CHECK;
            if (stat.arr_go) begin
               sidx_in  = '0;
               state_in = ST_ARR_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ARR_SCAN: begin
            cmd.op  = OP_SCAN_ARR;
            sidx_in = sidx_ff + IW'(1);
            if (scan_last) begin
               state_in = ST_ARR_APPLY;
            end
         end
         ST_ARR_APPLY: begin
            cmd.op   = OP_ARR_APPLY;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.op   = OP_DONE;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ridx_ff  <= '0;
         sidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ridx_ff  <= ridx_in;
         sidx_ff  <= sidx_in;
      end
   end

endmodule

// ===== rtl/ffalloc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffalloc_dp: tables and arithmetic of the first-fit job allocator
// Holds the free-segment table, the running table and the wait queue in
// memories, and carries out one controller command per cycle.
// ----------------------------------------------------------------------------
module ffalloc_dp #(
   parameter int RUN_SLOTS  = 32,
   parameter int WAIT_DEPTH = 32,
   parameter int ADDR_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ffalloc_pkg::cmd_type                 cmd,
   input  logic [$clog2(RUN_SLOTS + 2) - 1:0]   idx,
   input  ffalloc_pkg::req_type                 req_item,
   input  logic                                 csr_we,
   input  logic [15:0]                          csr_data,
   output ffalloc_pkg::stat_type                stat,
   output logic                                 rsp_valid,
   output ffalloc_pkg::rsp_type                 rsp_item
);
   import ffalloc_pkg::*;

   localparam int SEG_SLOTS = RUN_SLOTS + 1;
   localparam int AW = ADDR_BITS;
   localparam int IW = $clog2(RUN_SLOTS + 2);
   localparam int FW = $clog2(SEG_SLOTS);
   localparam int RW = $clog2(RUN_SLOTS);
   localparam int NW = $clog2(RUN_SLOTS + 1);
   localparam int WW = $clog2(WAIT_DEPTH);
   localparam int CW = $clog2(WAIT_DEPTH + 1);
   localparam int TW = WW + 1;
   localparam int LW = (AW + 1 > 17) ? AW + 1 : 17;

   // Memories.
   logic [AW-1:0] seg_start_mem [SEG_SLOTS];
   logic [AW-1:0] seg_end_mem   [SEG_SLOTS];
   logic [31:0]   run_fin_mem   [RUN_SLOTS];
   logic [AW-1:0] run_start_mem [RUN_SLOTS];
   logic [15:0]   run_len_mem   [RUN_SLOTS];
   logic [15:0]   wq_mem_mem    [WAIT_DEPTH];
   logic [15:0]   wq_run_mem    [WAIT_DEPTH];

   // Registered read data.
   logic [AW-1:0] seg_start_q, seg_end_q;
   logic [31:0]   run_fin_q;
   logic [AW-1:0] run_start_q;
   logic [15:0]   run_len_q;
   logic [15:0]   wq_mem_q, wq_run_q;

   // Tick state.
   logic [15:0]          mem_size_ff, mem_size_in;
   logic [31:0]          time_ff, time_in;
   req_type              job_ff, job_in;
   logic [31:0]          total_ff, total_in;
   logic [NW-1:0]        running_ff, running_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [WW-1:0]        head_ff, head_in;
   logic                 placed_ff, placed_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 dropped_ff, dropped_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [SEG_SLOTS-1:0] free_valid_ff, free_valid_in;
   logic [RUN_SLOTS-1:0] run_valid_ff, run_valid_in;
   logic [RW-1:0]        ridx_ff, ridx_in;
   logic                 seg_rd_vld_ff, seg_rd_vld_in;
   logic [FW-1:0]        seg_rd_idx_ff, seg_rd_idx_in;

   // Scan results.
   logic          below_found_ff, below_found_in;
   logic [FW-1:0] below_idx_ff, below_idx_in;
   logic          above_found_ff, above_found_in;
   logic [FW-1:0] above_idx_ff, above_idx_in;
   logic [AW-1:0] above_end_ff, above_end_in;
   logic          ins_found_ff, ins_found_in;
   logic [FW-1:0] ins_idx_ff, ins_idx_in;
   logic [AW-1:0] rel_s_ff, rel_s_in;
   logic [AW-1:0] rel_e_ff, rel_e_in;
   logic          seg_found_ff, seg_found_in;
   logic [FW-1:0] seg_idx_ff, seg_idx_in;
   logic [AW-1:0] seg_start_ff, seg_start_in;
   logic [AW-1:0] seg_end_ff, seg_end_in;
   logic          slot_found_ff, slot_found_in;
   logic [RW-1:0] slot_idx_ff, slot_idx_in;

   // Memory write controls.
   logic          seg_we_start, seg_we_end;
   logic [FW-1:0] seg_waddr;
   logic [AW-1:0] seg_wstart, seg_wend;
   logic          run_we, run_rd_en;
   logic          wq_we, wq_rd_en;
   logic [WW-1:0] wq_tail;

   // Helpers.
   logic          init;
   logic [15:0]   size_src;
   logic [LW-1:0] pool_w, pool_lim, pool;
   logic          is_scan, is_fit_scan, use_wait;
   logic [15:0]   need, run_src, run_ext;
   logic [31:0]   fin_time;
   logic [LW-1:0] cur_len, best_len;
   logic          cur_valid, expired, take_ok, do_take;
   logic [TW-1:0] tail_sum;

   assign init     = reset | csr_we;
   assign size_src = reset ? RESET_MEM_SIZE : (csr_we ? csr_data : mem_size_ff);

   // Pool limited to the address space.
   always_comb begin
      pool_w   = LW'(size_src);
      pool_lim = LW'(1) << AW;
      pool     = (pool_w > pool_lim) ? pool_lim : pool_w;
   end

   assign is_scan     = (cmd.op == OP_SCAN_REL) || (cmd.op == OP_SCAN_WAIT) ||
                        (cmd.op == OP_SCAN_ARR);
   assign is_fit_scan = (cmd.op == OP_SCAN_WAIT) || (cmd.op == OP_SCAN_ARR);
   assign use_wait    = (cmd.op == OP_SCAN_WAIT) || (cmd.op == OP_WAIT_APPLY);
   assign need        = use_wait ? wq_mem_q : job_ff.job_mem_len;
   assign run_src     = use_wait ? wq_run_q : job_ff.job_run_len;
   assign run_ext     = (run_src == '0) ? 16'd1 : run_src;
   assign fin_time    = time_ff + 32'(run_ext);
   assign cur_len     = LW'(seg_end_q) - LW'(seg_start_q) + LW'(1);
   assign best_len    = LW'(seg_end_ff) - LW'(seg_start_ff) + LW'(1);
   assign cur_valid   = free_valid_ff[seg_rd_idx_ff];
   assign expired     = run_valid_ff[ridx_ff] && (run_fin_q == time_ff);
   assign take_ok     = seg_found_ff && slot_found_ff;
   assign tail_sum    = TW'(head_ff) + TW'(fill_ff);
   assign wq_tail     = (tail_sum >= TW'(WAIT_DEPTH)) ? WW'(tail_sum - TW'(WAIT_DEPTH))
                                                      : WW'(tail_sum);

   assign stat.expired    = expired;
   assign stat.wait_nz    = (fill_ff != '0);
   assign stat.seg_found  = seg_found_ff;
   assign stat.slot_found = slot_found_ff;
   assign stat.arr_go     = job_ff.job_arrives && (job_ff.job_mem_len != '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Command execution.
   always_comb begin
      mem_size_in    = mem_size_ff;
      time_in        = time_ff;
      job_in         = job_ff;
      total_in       = total_ff;
      running_in     = running_ff;
      fill_in        = fill_ff;
      head_in        = head_ff;
      placed_in      = placed_ff;
      addr_in        = addr_ff;
      dropped_in     = dropped_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      free_valid_in  = free_valid_ff;
      run_valid_in   = run_valid_ff;
      ridx_in        = ridx_ff;
      seg_rd_vld_in  = 1'b0;
      seg_rd_idx_in  = idx[FW-1:0];
      below_found_in = below_found_ff;
      below_idx_in   = below_idx_ff;
      above_found_in = above_found_ff;
      above_idx_in   = above_idx_ff;
      above_end_in   = above_end_ff;
      ins_found_in   = ins_found_ff;
      ins_idx_in     = ins_idx_ff;
      rel_s_in       = rel_s_ff;
      rel_e_in       = rel_e_ff;
      seg_found_in   = seg_found_ff;
      seg_idx_in     = seg_idx_ff;
      seg_start_in   = seg_start_ff;
      seg_end_in     = seg_end_ff;
      slot_found_in  = slot_found_ff;
      slot_idx_in    = slot_idx_ff;
      seg_we_start   = 1'b0;
      seg_we_end     = 1'b0;
      seg_waddr      = '0;
      seg_wstart     = '0;
      seg_wend       = '0;
      run_we         = 1'b0;
      run_rd_en      = 1'b0;
      wq_we          = 1'b0;
      wq_rd_en       = 1'b0;
      do_take        = 1'b0;

      if (init) begin
         // Restart the pool with one free segment over the whole pool, if it is not empty.
         mem_size_in      = size_src;
         time_in          = '0;
         total_in         = '0;
         running_in       = '0;
         fill_in          = '0;
         head_in          = '0;
         placed_in        = 1'b0;
         dropped_in       = 1'b0;
         run_valid_in     = '0;
         free_valid_in    = '0;
         free_valid_in[0] = (pool != '0);
         seg_we_start     = 1'b1;
         seg_we_end       = 1'b1;
         seg_wend         = AW'(pool - LW'(1));
      end else begin
         // Free-table scan: issue one read, evaluate the previous one.
         if (is_scan) begin
            seg_rd_vld_in = cmd.scan_issue;
            if (cmd.scan_first) begin
               below_found_in = 1'b0;
               above_found_in = 1'b0;
               ins_found_in   = 1'b0;
               seg_found_in   = 1'b0;
               slot_found_in  = 1'b0;
            end else if (seg_rd_vld_ff) begin
               if (cmd.op == OP_SCAN_REL) begin
                  if (cur_valid) begin
                     if (LW'(seg_end_q) + LW'(1) == LW'(rel_s_ff)) begin
                        below_found_in = 1'b1;
                        below_idx_in   = seg_rd_idx_ff;
                     end
                     if (LW'(rel_e_ff) + LW'(1) == LW'(seg_start_q)) begin
                        above_found_in = 1'b1;
                        above_idx_in   = seg_rd_idx_ff;
                        above_end_in   = seg_end_q;
                     end
                  end else if (!ins_found_ff) begin
                     ins_found_in = 1'b1;
                     ins_idx_in   = seg_rd_idx_ff;
                  end
               end else if (cur_valid && (cur_len >= LW'(need)) &&
                            (!seg_found_ff || (seg_start_q < seg_start_ff))) begin
                  seg_found_in = 1'b1;
                  seg_idx_in   = seg_rd_idx_ff;
                  seg_start_in = seg_start_q;
                  seg_end_in   = seg_end_q;
               end
            end
            // The lowest free running slot is found alongside a fit scan.
            if (is_fit_scan && (idx < IW'(RUN_SLOTS)) && !slot_found_in &&
                !run_valid_ff[idx[RW-1:0]]) begin
               slot_found_in = 1'b1;
               slot_idx_in   = idx[RW-1:0];
            end
         end

         unique case (cmd.op)
            OP_LOAD: begin
               job_in     = req_item;
               time_in    = time_ff + 32'd1;
               placed_in  = 1'b0;
               addr_in    = '0;
               dropped_in = 1'b0;
            end
            OP_RUN_RD: begin
               ridx_in   = idx[RW-1:0];
               run_rd_en = 1'b1;
            end
            OP_RUN_CHK: begin
               if (expired) begin
                  run_valid_in[ridx_ff] = 1'b0;
                  running_in            = running_ff - NW'(1);
                  rel_s_in              = run_start_q;
                  rel_e_in              = AW'(LW'(run_start_q) + LW'(run_len_q) - LW'(1));
               end
            end
            OP_REL_APPLY: begin
               // Merge the released range with its neighbors, or enter it as a new segment.
               if (below_found_ff && above_found_ff) begin
                  seg_we_end                  = 1'b1;
                  seg_waddr                   = below_idx_ff;
                  seg_wend                    = above_end_ff;
                  free_valid_in[above_idx_ff] = 1'b0;
               end else if (below_found_ff) begin
                  seg_we_end = 1'b1;
                  seg_waddr  = below_idx_ff;
                  seg_wend   = rel_e_ff;
               end else if (above_found_ff) begin
                  seg_we_start = 1'b1;
                  seg_waddr    = above_idx_ff;
                  seg_wstart   = rel_s_ff;
               end else if (ins_found_ff) begin
                  seg_we_start              = 1'b1;
                  seg_we_end                = 1'b1;
                  seg_waddr                 = ins_idx_ff;
                  seg_wstart                = rel_s_ff;
                  seg_wend                  = rel_e_ff;
                  free_valid_in[ins_idx_ff] = 1'b1;
               end
            end
            OP_WAIT_RD: begin
               wq_rd_en = 1'b1;
            end
            OP_WAIT_APPLY: begin
               if (take_ok) begin
                  do_take = 1'b1;
                  head_in = (head_ff == WW'(WAIT_DEPTH - 1)) ? '0 : head_ff + WW'(1);
                  fill_in = fill_ff - CW'(1);
               end
            end
            OP_ARR_CHECK: begin
               dropped_in = job_ff.job_arrives && (job_ff.job_mem_len == '0);
            end
            OP_ARR_APPLY: begin
               if (take_ok) begin
                  do_take   = 1'b1;
                  placed_in = 1'b1;
                  addr_in   = seg_start_ff;
               end else if (seg_found_ff) begin
                  dropped_in = 1'b1;
               end else if (fill_ff < CW'(WAIT_DEPTH)) begin
                  wq_we    = 1'b1;
                  fill_in  = fill_ff + CW'(1);
                  total_in = total_ff + 32'd1;
               end else begin
                  dropped_in = 1'b1;
               end
            end
            OP_DONE: begin
               rsp_valid_in         = 1'b1;
               rsp_in.now_time      = time_ff;
               rsp_in.placed        = placed_ff;
               rsp_in.placed_addr   = 16'(addr_ff);
               rsp_in.waited_total  = total_ff;
               rsp_in.running_count = 6'(running_ff);
               rsp_in.waiting_count = 6'(fill_ff);
               rsp_in.dropped       = dropped_ff;
            end
            default: begin
            end
         endcase

         // Place a job at the low end of the chosen segment.
         if (do_take) begin
            if (best_len > LW'(need)) begin
               seg_we_start = 1'b1;
               seg_waddr    = seg_idx_ff;
               seg_wstart   = AW'(LW'(seg_start_ff) + LW'(need));
            end else begin
               free_valid_in[seg_idx_ff] = 1'b0;
            end
            run_we                    = 1'b1;
            run_valid_in[slot_idx_ff] = 1'b1;
            running_in                = running_ff + NW'(1);
         end
      end
   end

   // Free-segment table.
   always_ff @(posedge clock) begin
      if (seg_we_start) begin
         seg_start_mem[seg_waddr] <= seg_wstart;
      end
      if (seg_we_end) begin
         seg_end_mem[seg_waddr] <= seg_wend;
      end
      if (seg_rd_vld_in) begin
         seg_start_q <= seg_start_mem[idx[FW-1:0]];
         seg_end_q   <= seg_end_mem[idx[FW-1:0]];
      end
   end

   // Running table.
   always_ff @(posedge clock) begin
      if (run_we) begin
         run_fin_mem[slot_idx_ff]   <= fin_time;
         run_start_mem[slot_idx_ff] <= seg_start_ff;
         run_len_mem[slot_idx_ff]   <= need;
      end
      if (run_rd_en) begin
         run_fin_q   <= run_fin_mem[idx[RW-1:0]];
         run_start_q <= run_start_mem[idx[RW-1:0]];
         run_len_q   <= run_len_mem[idx[RW-1:0]];
      end
   end

   // Wait queue.
   always_ff @(posedge clock) begin
      if (wq_we) begin
         wq_mem_mem[wq_tail] <= job_ff.job_mem_len;
         wq_run_mem[wq_tail] <= job_ff.job_run_len;
      end
      if (wq_rd_en) begin
         wq_mem_q <= wq_mem_mem[head_ff];
         wq_run_q <= wq_run_mem[head_ff];
      end
   end

   // Registers; reset and pool restart are folded into the next values.
   always_ff @(posedge clock) begin
      mem_size_ff    <= mem_size_in;
      time_ff        <= time_in;
      job_ff         <= job_in;
      total_ff       <= total_in;
      running_ff     <= running_in;
      fill_ff        <= fill_in;
      head_ff        <= head_in;
      placed_ff      <= placed_in;
      addr_ff        <= addr_in;
      dropped_ff     <= dropped_in;
      rsp_valid_ff   <= rsp_valid_in;
      rsp_ff         <= rsp_in;
      free_valid_ff  <= free_valid_in;
      run_valid_ff   <= run_valid_in;
      ridx_ff        <= ridx_in;
      seg_rd_vld_ff  <= seg_rd_vld_in;
      seg_rd_idx_ff  <= seg_rd_idx_in;
      below_found_ff <= below_found_in;
      below_idx_ff   <= below_idx_in;
      above_found_ff <= above_found_in;
      above_idx_ff   <= above_idx_in;
      above_end_ff   <= above_end_in;
      ins_found_ff   <= ins_found_in;
      ins_idx_ff     <= ins_idx_in;
      rel_s_ff       <= rel_s_in;
      rel_e_ff       <= rel_e_in;
      seg_found_ff   <= seg_found_in;
      seg_idx_ff     <= seg_idx_in;
      seg_start_ff   <= seg_start_in;
      seg_end_ff     <= seg_end_in;
      slot_found_ff  <= slot_found_in;
      slot_idx_ff    <= slot_idx_in;
   end

endmodule

// ===== rtl/first_fit_memory_job_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_memory_job_allocator: first-fit job allocator with coalescing
// Top level: tick sequencer plus tables, one result item per tick.
// ----------------------------------------------------------------------------
// Each accepted item is one time tick and yields exactly one result item on
// rsp_item, marked by a one-cycle rsp_valid pulse that the receiver must
// take as it comes. busy is high from the cycle after start until the result
// is shown; start is taken whenever busy is low, also in the result cycle.
// A tick reads every running-table entry once from its memory. Each job that
// finishes, each queued job that is placed, a queue head that does not fit
// and an arrival with a nonzero length each add a walk of the free-segment
// memory entry by entry. csr_ready is low while a tick is in progress and
// while start is high; a write restarts the pool.
module first_fit_memory_job_allocator #(
   parameter int RUN_SLOTS  = ffalloc_pkg::RUN_SLOTS_DEF,
   parameter int WAIT_DEPTH = ffalloc_pkg::WAIT_DEPTH_DEF,
   parameter int ADDR_BITS  = ffalloc_pkg::ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ffalloc_pkg::req_type req_item,
   output logic                 rsp_valid,
   output ffalloc_pkg::rsp_type rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);
   import ffalloc_pkg::*;

   localparam int IW = $clog2(RUN_SLOTS + 2);

   cmd_type       cmd;
   stat_type      stat;
   logic [IW-1:0] idx;
   logic          csr_we;

   // Configuration is taken only between ticks, never beside a new item.
   assign csr_ready = !busy && !start;
   assign csr_we    = csr_valid && csr_ready;

   ffalloc_ctrl #(
      .RUN_SLOTS (RUN_SLOTS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd),
      .idx   (idx)
   );

   ffalloc_dp #(
      .RUN_SLOTS  (RUN_SLOTS),
      .WAIT_DEPTH (WAIT_DEPTH),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .idx       (idx),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_data  (csr_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // A result appears only once the sequencer is back in idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a tick is in progress");

   // An accepted item starts a tick.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start a tick");

   // One result per tick: the result strobe is never held high.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

endmodule

// ===== tb/first_fit_memory_job_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_memory_job_allocator_checker: tick predictor and result compare
// Watches the item, result and register channels of the allocator, keeps its
// own copy of the pool, running table and wait queue, and compares every
// result item field by field with the predicted tick outcome.
// ----------------------------------------------------------------------------
module first_fit_memory_job_allocator_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  ffalloc_pkg::req_type req_item,
   input  logic                 rsp_valid,
   input  ffalloc_pkg::rsp_type rsp_item,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [15:0]          csr_data,
   output int                   fail_count,
   output int                   pending_ticks
);
   import ffalloc_pkg::*;

   localparam int SLOTS = RUN_SLOTS_DEF;
   localparam int SEGS  = RUN_SLOTS_DEF + 1;
   localparam int DEPTH = WAIT_DEPTH_DEF;

   // Shadow copy of the allocator state.
   logic [15:0] pool_size;
   logic [31:0] tick_now;
   int          seg_lo [SEGS];
   int          seg_hi [SEGS];
   bit          seg_ok [SEGS];
   logic [31:0] job_finish [SLOTS];
   int          job_base [SLOTS];
   int          job_size [SLOTS];
   bit          job_live [SLOTS];
   int          queued_mem [DEPTH];
   logic [15:0] queued_run [DEPTH];
   int          queue_head;
   int          queue_fill;
   logic [31:0] queued_total;

   rsp_type     tick_outcomes[$];

   // Empty the pool and the tables; one free range covers the whole pool.
   function automatic void restart_pool();
      tick_now = '0;
      for (int i = 0; i < SEGS; i++) seg_ok[i] = 0;
      for (int i = 0; i < SLOTS; i++) job_live[i] = 0;
      queue_head = 0;
      queue_fill = 0;
      queued_total = '0;
      if (pool_size != 0) begin
         seg_lo[0] = 0;
         seg_hi[0] = int'(pool_size) - 1;
         seg_ok[0] = 1;
      end
   endfunction

   // Lowest-address free range that holds need units, or -1.
   function automatic int first_fit(int need);
      int pick;
      pick = -1;
      for (int i = 0; i < SEGS; i++) begin
         if (seg_ok[i] && seg_hi[i] - seg_lo[i] + 1 >= need &&
             (pick < 0 || seg_lo[i] < seg_lo[pick])) pick = i;
      end
      return pick;
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < SLOTS; i++)
         if (!job_live[i]) return i;
      return -1;
   endfunction

   // Carve a job from the low end of a free range.
   function automatic int carve(int seg, int slot, int need, logic [15:0] run);
      int base;
      base = seg_lo[seg];
      if (seg_hi[seg] - base + 1 > need) seg_lo[seg] = base + need;
      else seg_ok[seg] = 0;
      job_base[slot] = base;
      job_size[slot] = need;
      job_finish[slot] = tick_now + ((run == 0) ? 32'd1 : 32'(run));
      job_live[slot] = 1;
      return base;
   endfunction

   // Return a range to the free list, merging with neighbors on both sides.
   function automatic void give_back(int lo, int hi);
      int below, above;
      below = -1;
      above = -1;
      for (int i = 0; i < SEGS; i++) begin
         if (seg_ok[i]) begin
            if (seg_hi[i] + 1 == lo) below = i;
            if (hi + 1 == seg_lo[i]) above = i;
         end
      end
      if (below >= 0 && above >= 0) begin
         seg_hi[below] = seg_hi[above];
         seg_ok[above] = 0;
      end else if (below >= 0) begin
         seg_hi[below] = hi;
      end else if (above >= 0) begin
         seg_lo[above] = lo;
      end else begin
         for (int i = 0; i < SEGS; i++) begin
            if (!seg_ok[i]) begin
               seg_lo[i] = lo;
               seg_hi[i] = hi;
               seg_ok[i] = 1;
               return;
            end
         end
      end
   endfunction

   // Advance one tick and return the result item it should produce.
   function automatic rsp_type run_tick(req_type job);
      rsp_type outcome;
      int      slot, seg, need, live;
      outcome = '0;
      tick_now = tick_now + 1;
      for (int i = 0; i < SLOTS; i++) begin
         if (job_live[i] && job_finish[i] == tick_now) begin
            job_live[i] = 0;
            give_back(job_base[i], job_base[i] + job_size[i] - 1);
         end
      end
      // Serve the wait queue head first while the head fits and a running slot is free.
      while (queue_fill > 0) begin
         slot = free_slot();
         if (slot < 0) break;
         seg = first_fit(queued_mem[queue_head]);
         if (seg < 0) break;
         void'(carve(seg, slot, queued_mem[queue_head], queued_run[queue_head]));
         queue_head = (queue_head + 1) % DEPTH;
         queue_fill--;
      end
      if (job.job_arrives) begin
         need = int'(job.job_mem_len);
         if (need == 0) begin
            outcome.dropped = 1;
         end else begin
            seg = first_fit(need);
            if (seg >= 0) begin
               slot = free_slot();
               if (slot < 0) begin
                  outcome.dropped = 1;
               end else begin
                  outcome.placed_addr = 16'(carve(seg, slot, need, job.job_run_len));
                  outcome.placed = 1;
               end
            end else if (queue_fill < DEPTH) begin
               queued_mem[(queue_head + queue_fill) % DEPTH] = need;
               queued_run[(queue_head + queue_fill) % DEPTH] = job.job_run_len;
               queue_fill++;
               queued_total = queued_total + 1;
            end else begin
               outcome.dropped = 1;
            end
         end
      end
      live = 0;
      for (int i = 0; i < SLOTS; i++) live += job_live[i];
      outcome.now_time = tick_now;
      outcome.waited_total = queued_total;
      outcome.running_count = 6'(live);
      outcome.waiting_count = 6'(queue_fill);
      return outcome;
   endfunction

   // Compare results first: a tick accepted in the result cycle is still ahead.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type next_outcome;
      if (reset) begin
         pool_size = RESET_MEM_SIZE;
         restart_pool();
         tick_outcomes.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (tick_outcomes.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("%t: result item with no tick pending: %p", $realtime, rsp_item);
            end else begin
               want = tick_outcomes.pop_front();
               if (rsp_item !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("%t: tick result mismatch", $realtime);
                     $display("   expected %p", want);
                     $display("   actual   %p", rsp_item);
                  end
               end
            end
         end
         if (start && !busy) begin
            next_outcome = run_tick(req_item);
            tick_outcomes.insert(tick_outcomes.size(), next_outcome);
         end
         if (csr_valid && csr_ready) begin
            pool_size = csr_data;
            restart_pool();
         end
      end
      pending_ticks <= tick_outcomes.size();
   end

endmodule

// ===== tb/first_fit_memory_job_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_memory_job_allocator_tb: regression of the first-fit allocator
// Drives directed and random ticks over several pool sizes, with random
// gaps between ticks, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module first_fit_memory_job_allocator_tb;
   import ffalloc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   int          fail_count;
   int          pending_ticks;
   int          ticks_sent = 0;
   int          gap_pct = 24;
   int          quiet_cycles = 0;

   always #10 clock = ~clock;

   first_fit_memory_job_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   first_fit_memory_job_allocator_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_ticks(pending_ticks)
   );

   // Watchdog: any handshake counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("first_fit_memory_job_allocator regression: fail");
         $finish;
      end
   end

   // Present one tick, with a random gap ahead of it, until it is taken.
   task automatic send_tick(req_type job);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      start <= 1;
      req_item <= job;
      @(posedge clock);
      while (busy) @(posedge clock);
      ticks_sent++;
      if (ticks_sent == 170) gap_pct = 68;
      if (ticks_sent == 340) gap_pct = 0;
   endtask

   task automatic send_job(bit arrives, logic [15:0] mem_len, logic [15:0] run_len);
      req_type job;
      job.job_arrives = arrives;
      job.job_mem_len = mem_len;
      job.job_run_len = run_len;
      send_tick(job);
   endtask

   // Hold off until every predicted result has come back.
   task automatic drain();
      start <= 0;
      @(posedge clock);
      @(posedge clock);
      while (pending_ticks != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_pool(logic [15:0] units);
      drain();
      csr_valid <= 1;
      csr_data <= units;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // Random ticks: mostly well-formed jobs sized to the pool, some noise.
   task automatic random_ticks(int count, int max_mem, int max_run);
      req_type job;
      int      pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         job.job_arrives = (pick >= 8);
         job.job_mem_len = 16'($urandom_range(max_mem, 1));
         job.job_run_len = 16'($urandom_range(max_run, 1));
         if (pick < 8) begin
            job.job_mem_len = 16'($urandom);
            job.job_run_len = 16'($urandom);
         end else if (pick < 11) job.job_mem_len = '0;
         else if (pick < 14) job.job_mem_len = 16'($urandom);
         else if (pick < 16) job.job_run_len = '0;
         else if (pick < 18) job.job_run_len = 16'($urandom);
         send_tick(job);
         if (n == count / 2 && count > 60) drain();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;

      // Directed ticks on the reset pool of 65535 units.
      send_job(0, 16'hFFFF, 16'hFFFF);
      send_job(1, 16'd0, 16'd5);
      send_job(1, 16'd10, 16'd0);
      send_job(1, 16'hFFFF, 16'd3);
      send_job(1, 16'd1, 16'd1);
      send_job(1, 16'd2, 16'd4);
      send_job(0, 16'd0, 16'd0);
      send_job(1, 16'd65525, 16'd2);
      send_job(1, 16'd30, 16'd2);
      send_job(1, 16'd5, 16'd1);
      send_job(1, 16'd1, 16'hFFFF);
      send_job(0, 16'd0, 16'd0);
      send_job(1, 16'd20, 16'd1);
      send_job(0, 16'd0, 16'd0);
      drain();

      // Random phases over several pool sizes, extremes included.
      random_ticks(110, 8000, 20);
      set_pool(16'd64);
      random_ticks(110, 12, 6);
      set_pool(16'd1);
      send_job(1, 16'd2, 16'd1);
      random_ticks(50, 1, 3);
      set_pool(16'd0);
      random_ticks(20, 4, 3);
      set_pool(16'd1000);
      random_ticks(130, 40, 60);
      set_pool(16'hFFFF);
      random_ticks(60, 16'hFFFF, 8);
      drain();
      repeat (20) @(posedge clock);

      $display("Ran %0d ticks over pool sizes 65535, 64, 1, 0 and 1000,", ticks_sent);
      $display("with merging, queue blocking, full tables and dropped arrivals.");
      if (fail_count == 0) begin
         $display("first_fit_memory_job_allocator regression: pass");
      end else begin
         $display("first_fit_memory_job_allocator regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ffalloc_pkg.sv
rtl/ffalloc_ctrl.sv
rtl/ffalloc_dp.sv
rtl/first_fit_memory_job_allocator.sv
tb/first_fit_memory_job_allocator_checker.sv
tb/first_fit_memory_job_allocator_tb.sv
